/* hw/rtl/clsl_pkg.sv */
// Shared types, constants and keyword tables of the C-like source lexer.
`default_nettype none
package clsl_pkg;

	localparam int LINE_WIDTH = 20;
	localparam int COL_WIDTH  = 16;
	localparam int LEN_WIDTH  = 16;
	localparam int NKW        = 13;
	localparam int KW_MAXLEN  = 9;
	localparam int QDEPTH     = 4;
	localparam int QAW        = $clog2(QDEPTH);

	typedef enum logic [3:0] {
		M_IDLE, M_ZERO, M_NUM, M_IDENT, M_STRING, M_ESCAPE,
		M_OP, M_LINECOM, M_BLKFIRST, M_BLOCK
	} mode_t;

	localparam logic [1:0] KIND_TOKEN = 2'd0;
	localparam logic [1:0] KIND_TEXT  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] ERR_UNEXPECTED = 2'd0;
	localparam logic [1:0] ERR_UNTERM     = 2'd1;
	localparam logic [1:0] ERR_ESCAPE     = 2'd2;

	localparam logic [5:0] T_INT      = 6'd0;
	localparam logic [5:0] T_IDENT    = 6'd1;
	localparam logic [5:0] T_STRING   = 6'd2;
	localparam logic [5:0] T_KW0      = 6'd3;
	localparam logic [5:0] T_LPAREN   = 6'd16;
	localparam logic [5:0] T_RPAREN   = 6'd17;
	localparam logic [5:0] T_LBRACE   = 6'd18;
	localparam logic [5:0] T_RBRACE   = 6'd19;
	localparam logic [5:0] T_LBRACK   = 6'd20;
	localparam logic [5:0] T_RBRACK   = 6'd21;
	localparam logic [5:0] T_SEMI     = 6'd22;
	localparam logic [5:0] T_COMMA    = 6'd23;
	localparam logic [5:0] T_DOT      = 6'd24;
	localparam logic [5:0] T_ASSIGN   = 6'd25;
	localparam logic [5:0] T_PLUS     = 6'd26;
	localparam logic [5:0] T_MINUS    = 6'd27;
	localparam logic [5:0] T_STAR     = 6'd28;
	localparam logic [5:0] T_SLASH    = 6'd29;
	localparam logic [5:0] T_PERCENT  = 6'd30;
	localparam logic [5:0] T_AMP      = 6'd31;
	localparam logic [5:0] T_PIPE     = 6'd32;
	localparam logic [5:0] T_CARET    = 6'd33;
	localparam logic [5:0] T_TILDE    = 6'd34;
	localparam logic [5:0] T_BANG     = 6'd35;
	localparam logic [5:0] T_ANDAND   = 6'd36;
	localparam logic [5:0] T_OROR     = 6'd37;
	localparam logic [5:0] T_SHL      = 6'd38;
	localparam logic [5:0] T_SHR      = 6'd39;
	localparam logic [5:0] T_EQ       = 6'd40;
	localparam logic [5:0] T_NE       = 6'd41;
	localparam logic [5:0] T_LT       = 6'd42;
	localparam logic [5:0] T_LE       = 6'd43;
	localparam logic [5:0] T_GT       = 6'd44;
	localparam logic [5:0] T_GE       = 6'd45;
	localparam logic [5:0] T_EOF      = 6'd46;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
	} src_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [5:0]            token_type;
		logic [LINE_WIDTH-1:0] start_line;
		logic [COL_WIDTH-1:0]  start_column;
		logic signed [31:0]    lit_value;
		logic [LEN_WIDTH-1:0]  text_len;
		logic                  has_doc;
		logic [7:0]            text_byte;
		logic [1:0]            error_code;
		logic                  last_of_step;
	} res_t;

	// results of one accepted beat, in order
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} front_out_t;

	typedef struct packed {
		logic [QAW:0] count;
	} back_stat_t;

	function automatic logic [3:0] kw_len(input int k);
		logic [3:0] l;
		case (k)
			0: l = 4'd3;  1: l = 4'd2;  2: l = 4'd4;  3: l = 4'd5;
			4: l = 4'd3;  5: l = 4'd6;  6: l = 4'd9;  7: l = 4'd7;
			8: l = 4'd6;  9: l = 4'd6;  10: l = 4'd4; 11: l = 4'd4;
			12: l = 4'd7;
			default: l = 4'd0;
		endcase
		return l;
	endfunction

	function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
		logic [8*KW_MAXLEN-1:0] s;
		case (k)
			0: s = {"int", 48'h0};
			1: s = {"if", 56'h0};
			2: s = {"else", 40'h0};
			3: s = {"while", 32'h0};
			4: s = {"for", 48'h0};
			5: s = {"return", 24'h0};
			6: s = "recursive";
			7: s = {"include", 16'h0};
			8: s = {"struct", 24'h0};
			9: s = {"extern", 24'h0};
			10: s = {"void", 40'h0};
			11: s = {"byte", 40'h0};
			12: s = {"version", 16'h0};
			default: s = '0;
		endcase
		return s[8*(KW_MAXLEN-1-int'(i)) +: 8];
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/clsl_front.sv */
// Lexer front end: per-beat state update and result classification.
`default_nettype none
module clsl_front import clsl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire src_t       src,
	output front_out_t      fo
);

	localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;
	localparam logic [COL_WIDTH-1:0]  COL_MAX  = '1;
	localparam logic [LEN_WIDTH-1:0]  LEN_MAX  = '1;

	mode_t                 mode_q, m;
	logic [7:0]            pop_q, p;
	logic [LINE_WIDTH-1:0] cl_q, cl, tl_q, tl;
	logic [COL_WIDTH-1:0]  cc_q, cc, tc_q, tc;
	logic [63:0]           acc_q, acc;
	logic                  ovf_q, ovf, hex_q, hex;
	logic [LEN_WIDTH-1:0]  cnt_q, cnt;
	logic [NKW-1:0]        km_q, km;
	logic                  doc_q, doc, cdoc_q, cdoc, star_q, star, dead_q, dead;

	logic [7:0]  c;
	logic        is_end_b, fall_idle, do_ident, do_num, failed;
	logic [5:0]  t;
	logic [67:0] ten;
	logic [3:0]  hv;
	logic [8:0]  esc;

	function automatic res_t mk(input logic [1:0] kind, input logic [5:0] ty,
		input logic [LINE_WIDTH-1:0] ln, input logic [COL_WIDTH-1:0] col,
		input logic [31:0] val, input logic [LEN_WIDTH-1:0] len, input logic dc,
		input logic [7:0] b, input logic [1:0] err);
		res_t r;
		r.kind = kind; r.token_type = ty; r.start_line = ln; r.start_column = col;
		r.lit_value = signed'(val); r.text_len = len; r.has_doc = dc;
		r.text_byte = b; r.error_code = err; r.last_of_step = 1'b0;
		return r;
	endfunction

	function automatic front_out_t put(input front_out_t f, input res_t r);
		front_out_t g;
		g = f;
		if (f.n == 2'd0) g.r0 = r;
		else g.r1 = r;
		g.n = f.n + 2'd1;
		return g;
	endfunction

	function automatic logic is_digit(input logic [7:0] x);
		return x >= "0" && x <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] x);
		return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || x == "_";
	endfunction

	function automatic logic [5:0] op_alone(input logic [7:0] x);
		logic [5:0] r;
		case (x)
			"=": r = T_ASSIGN;
			"!": r = T_BANG;
			"&": r = T_AMP;
			"|": r = T_PIPE;
			"<": r = T_LT;
			">": r = T_GT;
			default: r = T_SLASH;
		endcase
		return r;
	endfunction

	always_comb begin
		m = mode_q; p = pop_q; cl = cl_q; cc = cc_q; tl = tl_q; tc = tc_q;
		acc = acc_q; ovf = ovf_q; hex = hex_q; cnt = cnt_q; km = km_q;
		doc = doc_q; cdoc = cdoc_q; star = star_q; dead = dead_q;
		fo = '0;
		c = src.ch;
		is_end_b = src.is_end || (c == 8'd0);
		fall_idle = 1'b0; do_ident = 1'b0; do_num = 1'b0; failed = 1'b0;
		t = '0; ten = '0; hv = '0; esc = '0;
		if (accept) begin
			if (is_end_b) begin
				if (!dead_q) begin
					case (m)
						M_ZERO, M_NUM: begin
							fo = put(fo, mk(KIND_TOKEN, T_INT, tl, tc,
								ovf ? 32'hFFFF_FFFF : acc[31:0], '0, doc, 8'd0, 2'd0));
						end
						M_IDENT: begin
							t = T_IDENT;
							for (int k = NKW - 1; k >= 0; k--)
								if (km[k] && cnt == LEN_WIDTH'(kw_len(k))) t = T_KW0 + 6'(k);
							fo = put(fo, mk(KIND_TOKEN, t, tl, tc, '0, cnt, doc, 8'd0, 2'd0));
						end
						M_OP: fo = put(fo, mk(KIND_TOKEN, op_alone(p), tl, tc, '0, '0, doc,
							8'd0, 2'd0));
						M_STRING: begin
							fo = put(fo, mk(KIND_ERROR, 6'd0, tl, tc, '0, '0, 1'b0, 8'd0,
								ERR_UNTERM));
							failed = 1'b1;
						end
						M_ESCAPE: begin
							fo = put(fo, mk(KIND_ERROR, 6'd0, cl, cc, '0, '0, 1'b0, 8'd0,
								ERR_ESCAPE));
							failed = 1'b1;
						end
						default: ;
					endcase
					if (!failed)
						fo = put(fo, mk(KIND_TOKEN, T_EOF, cl, cc, '0, '0, 1'b0, 8'd0, 2'd0));
				end
				// return to the reset state
				m = M_IDLE; p = '0; cl = LINE_WIDTH'(1); cc = COL_WIDTH'(1);
				tl = LINE_WIDTH'(1); tc = COL_WIDTH'(1); acc = '0; ovf = 1'b0; hex = 1'b0;
				cnt = '0; km = '0; doc = 1'b0; cdoc = 1'b0; star = 1'b0; dead = 1'b0;
			end else if (!dead_q) begin
				case (m)
					M_ZERO: begin
						if (c == "x" || c == "X") begin
							hex = 1'b1; acc = '0; m = M_NUM;
						end else if (!is_digit(c)) begin
							fo = put(fo, mk(KIND_TOKEN, T_INT, tl, tc,
								ovf ? 32'hFFFF_FFFF : acc[31:0], '0, doc, 8'd0, 2'd0));
							doc = 1'b0;
							fall_idle = 1'b1;
						end else begin
							m = M_NUM;
							do_num = 1'b1;
						end
					end
					M_NUM: do_num = 1'b1;
					M_IDENT: begin
						if (is_alpha(c) || is_digit(c)) do_ident = 1'b1;
						else begin
							t = T_IDENT;
							for (int k = NKW - 1; k >= 0; k--)
								if (km[k] && cnt == LEN_WIDTH'(kw_len(k))) t = T_KW0 + 6'(k);
							fo = put(fo, mk(KIND_TOKEN, t, tl, tc, '0, cnt, doc, 8'd0, 2'd0));
							doc = 1'b0;
							fall_idle = 1'b1;
						end
					end
					M_STRING: begin
						if (c == "\"") begin
							fo = put(fo, mk(KIND_TOKEN, T_STRING, tl, tc, '0, cnt, doc, 8'd0,
								2'd0));
							doc = 1'b0;
							m = M_IDLE;
						end else if (c == 8'h0A) begin
							fo = put(fo, mk(KIND_ERROR, 6'd0, tl, tc, '0, '0, 1'b0, 8'd0,
								ERR_UNTERM));
							dead = 1'b1;
						end else if (c == "\\") begin
							m = M_ESCAPE;
						end else begin
							fo = put(fo, mk(KIND_TEXT, T_STRING, tl, tc, '0, '0, 1'b0, c, 2'd0));
							if (cnt < LEN_MAX) cnt = cnt + 1'b1;
						end
					end
					M_ESCAPE: begin
						case (c)
							"n": esc = 9'h00A;
							"t": esc = 9'h009;
							"r": esc = 9'h00D;
							"0": esc = 9'h000;
							"\\": esc = 9'h05C;
							"\"": esc = 9'h022;
							default: esc = 9'h100;
						endcase
						if (esc[8]) begin
							fo = put(fo, mk(KIND_ERROR, 6'd0, cl, cc, '0, '0, 1'b0, 8'd0,
								ERR_ESCAPE));
							dead = 1'b1;
						end else begin
							fo = put(fo, mk(KIND_TEXT, T_STRING, tl, tc, '0, '0, 1'b0, esc[7:0],
								2'd0));
							if (cnt < LEN_MAX) cnt = cnt + 1'b1;
							m = M_STRING;
						end
					end
					M_OP: begin
						if (p == "/" && c == "/") begin
							doc = 1'b0; m = M_LINECOM;
						end else if (p == "/" && c == "*") begin
							m = M_BLKFIRST;
						end else begin
							if (c == "=" && (p inside {"=", "!", "<", ">"}))
								t = (p == "=") ? T_EQ : (p == "!") ? T_NE : (p == "<") ? T_LE : T_GE;
							else if (c == p && (p inside {"&", "|", "<", ">"}))
								t = (p == "&") ? T_ANDAND : (p == "|") ? T_OROR :
									(p == "<") ? T_SHL : T_SHR;
							if (t != 6'd0) begin
								fo = put(fo, mk(KIND_TOKEN, t, tl, tc, '0, '0, doc, 8'd0, 2'd0));
								doc = 1'b0;
								m = M_IDLE;
							end else begin
								fo = put(fo, mk(KIND_TOKEN, op_alone(p), tl, tc, '0, '0, doc,
									8'd0, 2'd0));
								doc = 1'b0;
								fall_idle = 1'b1;
							end
						end
					end
					M_LINECOM: if (c == 8'h0A) m = M_IDLE;
					M_BLKFIRST: begin
						cdoc = (c == "*"); star = (c == "*"); m = M_BLOCK;
					end
					M_BLOCK: begin
						if (star && c == "/") begin
							doc = cdoc; m = M_IDLE;
						end else star = (c == "*");
					end
					default: fall_idle = 1'b1;
				endcase

				// digit of a number in progress
				if (do_num) begin
					if (hex) begin
						if (is_digit(c)) hv = 4'(c - "0");
						else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
						else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
						if (!(is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
							begin
							fo = put(fo, mk(KIND_TOKEN, T_INT, tl, tc,
								ovf ? 32'hFFFF_FFFF : acc[31:0], '0, doc, 8'd0, 2'd0));
							doc = 1'b0;
							fall_idle = 1'b1;
						end else begin
							if (acc[63:60] != 4'd0) ovf = 1'b1;
							if (!ovf) acc = {acc[59:0], hv};
						end
					end else begin
						if (!is_digit(c)) begin
							fo = put(fo, mk(KIND_TOKEN, T_INT, tl, tc,
								ovf ? 32'hFFFF_FFFF : acc[31:0], '0, doc, 8'd0, 2'd0));
							doc = 1'b0;
							fall_idle = 1'b1;
						end else begin
							ten = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + {60'd0, c - "0"};
							if (ten > {5'd0, 63'h7FFF_FFFF_FFFF_FFFF}) ovf = 1'b1;
							if (!ovf) acc = ten[63:0];
						end
					end
				end

				// byte seen from the idle state
				if (fall_idle) begin
					m = M_IDLE;
					if (c inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
						m = M_IDLE;
					end else if (is_digit(c)) begin
						tl = cl; tc = cc;
						acc = {56'd0, c - "0"}; ovf = 1'b0; hex = 1'b0;
						m = (c == "0") ? M_ZERO : M_NUM;
					end else if (is_alpha(c)) begin
						tl = cl; tc = cc;
						cnt = '0; km = '1; m = M_IDENT;
						do_ident = 1'b1;
					end else if (c == "\"") begin
						tl = cl; tc = cc; cnt = '0; m = M_STRING;
					end else if (c inside {"=", "!", "&", "|", "<", ">", "/"}) begin
						tl = cl; tc = cc; p = c; m = M_OP;
					end else begin
						case (c)
							"(": t = T_LPAREN;  ")": t = T_RPAREN;
							"{": t = T_LBRACE;  "}": t = T_RBRACE;
							"[": t = T_LBRACK;  "]": t = T_RBRACK;
							";": t = T_SEMI;    ",": t = T_COMMA;
							".": t = T_DOT;     "+": t = T_PLUS;
							"-": t = T_MINUS;   "*": t = T_STAR;
							"%": t = T_PERCENT; "^": t = T_CARET;
							"~": t = T_TILDE;
							default: t = 6'd0;
						endcase
						if (t != 6'd0) begin
							fo = put(fo, mk(KIND_TOKEN, t, cl, cc, '0, '0, doc, 8'd0, 2'd0));
							doc = 1'b0;
						end else begin
							fo = put(fo, mk(KIND_ERROR, 6'd0, cl, cc, '0, '0, 1'b0, 8'd0,
								ERR_UNEXPECTED));
						end
					end
				end

				// identifier character: narrow the keyword candidates
				if (do_ident) begin
					for (int k = 0; k < NKW; k++)
						if (cnt >= LEN_WIDTH'(kw_len(k)) || kw_char(k, cnt[3:0]) != c)
							km[k] = 1'b0;
					fo = put(fo, mk(KIND_TEXT, T_IDENT, tl, tc, '0, '0, 1'b0, c, 2'd0));
					if (cnt < LEN_MAX) cnt = cnt + 1'b1;
				end

				if (c == 8'h0A) begin
					if (cl < LINE_MAX) cl = cl + 1'b1;
					cc = COL_WIDTH'(1);
				end else if (cc < COL_MAX) cc = cc + 1'b1;
			end
			if (fo.n == 2'd1) fo.r0.last_of_step = 1'b1;
			if (fo.n == 2'd2) fo.r1.last_of_step = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pop_q <= '0;
			cl_q <= LINE_WIDTH'(1); cc_q <= COL_WIDTH'(1);
			tl_q <= LINE_WIDTH'(1); tc_q <= COL_WIDTH'(1);
			acc_q <= '0; ovf_q <= 1'b0; hex_q <= 1'b0; cnt_q <= '0; km_q <= '0;
			doc_q <= 1'b0; cdoc_q <= 1'b0; star_q <= 1'b0; dead_q <= 1'b0;
		end else if (accept) begin
			mode_q <= m; pop_q <= p; cl_q <= cl; cc_q <= cc; tl_q <= tl; tc_q <= tc;
			acc_q <= acc; ovf_q <= ovf; hex_q <= hex; cnt_q <= cnt; km_q <= km;
			doc_q <= doc; cdoc_q <= cdoc; star_q <= star; dead_q <= dead;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/clsl_back.sv */
// Result queue: takes up to two results a beat, hands out one per pop.
`default_nettype none
module clsl_back import clsl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire front_out_t fo,
	input  wire logic       pop,
	output logic            full,
	output logic            empty,
	output res_t            head,
	output back_stat_t      stat
);

	res_t           ent_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q, wr_next;
	logic [QAW:0]   count_q;
	logic           do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q > (QAW+1)'(QDEPTH - 2));
	assign do_pop  = pop && !empty;
	assign head    = ent_q[rd_ptr_q];
	assign wr_next = wr_ptr_q + 1'b1;
	assign stat.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(fo.n);
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (QAW+1)'(fo.n) - (QAW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (fo.n != 2'd0) ent_q[wr_ptr_q] <= fo.r0;
		if (fo.n == 2'd2) ent_q[wr_next] <= fo.r1;
	end

endmodule
`default_nettype wire

/* hw/rtl/c_like_source_lexer_top.sv */
// Top level of the streaming C-like source lexer.
// Usage:
//  Source bytes enter on src as a queue write: a beat is taken at a rising
//  edge with push high and full low. A zero byte or is_end marks end of
//  input; it flushes any pending token, emits EOF if no string error
//  arose, and rewinds the lexer. Results leave on tok as a queue read:
//  the oldest record is shown while empty is low and leaves at an edge
//  with pop high. Each byte yields zero, one or two records; last_of_step
//  flags the final record of a byte.
//  A record is written to the queue at the edge that takes its byte and
//  is on tok after that edge if nothing older waits.
//  Throughput: one byte per cycle while full is low; the lexer state update
//  is combinational, and the four-entry result queue absorbs two records
//  per beat. full rises once three or more records wait, so a stalled
//  reader backs pressure into the writer after two beats of two records
//  or three beats of one record; no record is ever lost.
//  Reset (arst_n low) clears the lexer state and empties the queue.
`default_nettype none
module c_like_source_lexer_top import clsl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire src_t src,
	output logic      empty,
	input  wire logic pop,
	output res_t      tok
);

	logic       accept;
	front_out_t fo;
	back_stat_t stat;

	// take a beat only when two slots are guaranteed
	assign accept = push && !full;

	clsl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.src    (src),
		.fo     (fo)
	);

	clsl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fo     (fo),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (tok),
		.stat   (stat)
	);

	// queue occupancy never runs past its depth
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= (QAW+1)'(QDEPTH))
		else $error("result queue overrun");

	// no results appear without an accepted beat
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> fo.n == 2'd0)
		else $error("result without accepted beat");

	// error records carry no token type
	a_err_type: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && tok.kind == KIND_ERROR) |-> tok.token_type == T_INT)
		else $error("error record with token type");

endmodule
`default_nettype wire

/* verif/c_like_source_lexer_checker.sv */
// Checker for the C-like source lexer: predicts token, text and error records and compares.
`timescale 1ns / 100ps
module c_like_source_lexer_checker import clsl_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire src_t src,
	input wire logic empty,
	input wire logic pop,
	input wire res_t tok,
	output int       fail_count,
	output int       pending_count
);
	localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;
	localparam logic [COL_WIDTH-1:0]  COL_MAX  = '1;
	localparam logic [LEN_WIDTH-1:0]  LEN_MAX  = '1;

	mode_t                 mode;
	logic [7:0]            op_char;
	logic [LINE_WIDTH-1:0] line_no, tok_line;
	logic [COL_WIDTH-1:0]  col_no, tok_col;
	logic [63:0]           accum;
	logic                  ovf, hex, doc, in_doc, star, dead;
	logic [LEN_WIDTH-1:0]  tlen;
	logic [NKW-1:0]        kw_hits;
	res_t                  step_recs[$];
	res_t                  expected_recs[$];

	function automatic logic [7:0] kw_byte(int k, int i);
		string s;
		case (k)
			0: s = "int"; 1: s = "if"; 2: s = "else"; 3: s = "while"; 4: s = "for";
			5: s = "return"; 6: s = "recursive"; 7: s = "include"; 8: s = "struct";
			9: s = "extern"; 10: s = "void"; 11: s = "byte"; default: s = "version";
		endcase
		return (i < s.len()) ? s[i] : 8'h00;
	endfunction

	function automatic int kw_size(int k);
		int i;
		i = 0;
		while (kw_byte(k, i) != 0) i++;
		return i;
	endfunction

	task automatic put(logic [1:0] kd, logic [5:0] ty, logic [LINE_WIDTH-1:0] ln,
			logic [COL_WIDTH-1:0] cl, logic [31:0] v, logic [LEN_WIDTH-1:0] len,
			logic dc, logic [7:0] b, logic [1:0] ec);
		res_t r;
		if (step_recs.size() >= 2) return;
		r = '{kd, ty, ln, cl, v, len, dc, b, ec, 1'b0};
		step_recs.push_back(r);
	endtask

	task automatic put_token(logic [5:0] ty, logic [LINE_WIDTH-1:0] ln,
			logic [COL_WIDTH-1:0] cl, logic [31:0] v, logic [LEN_WIDTH-1:0] len);
		put(KIND_TOKEN, ty, ln, cl, v, len, doc, 8'h00, 2'd0);
		doc = 1'b0;
	endtask

	task automatic put_error(logic [1:0] ec, logic [LINE_WIDTH-1:0] ln, logic [COL_WIDTH-1:0] cl);
		put(KIND_ERROR, T_INT, ln, cl, 32'h0, '0, 1'b0, 8'h00, ec);
	endtask

	task automatic put_text(logic [5:0] ty, logic [7:0] b);
		put(KIND_TEXT, ty, tok_line, tok_col, 32'h0, '0, 1'b0, b, 2'd0);
		if (tlen != LEN_MAX) tlen++;
	endtask

	function automatic bit digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	task automatic flush_number();
		put_token(T_INT, tok_line, tok_col, ovf ? 32'hFFFF_FFFF : accum[31:0], '0);
	endtask

	task automatic flush_word();
		logic [5:0] ty;
		ty = T_IDENT;
		for (int k = NKW - 1; k >= 0; k--)
			if (kw_hits[k] && tlen == kw_size(k)) ty = T_KW0 + 6'(k);
		put_token(ty, tok_line, tok_col, 32'h0, tlen);
	endtask

	task automatic flush_op();
		logic [5:0] ty;
		case (op_char)
			"=": ty = T_ASSIGN; "!": ty = T_BANG; "&": ty = T_AMP; "|": ty = T_PIPE;
			"<": ty = T_LT; ">": ty = T_GT; default: ty = T_SLASH;
		endcase
		put_token(ty, tok_line, tok_col, 32'h0, '0);
	endtask

	task automatic word_char(logic [7:0] c);
		for (int k = 0; k < NKW; k++)
			if (tlen >= kw_size(k) || kw_byte(k, tlen) != c) kw_hits[k] = 1'b0;
		put_text(T_IDENT, c);
	endtask

	task automatic mark_start();
		tok_line = line_no;
		tok_col = col_no;
	endtask

	task automatic scan_idle(logic [7:0] c);
		logic [5:0] ty;
		mode = M_IDLE;
		if (c inside {" ", "\t", "\r", "\n"}) return;
		if (digit(c)) begin
			mark_start();
			accum = 64'(c - "0");
			ovf = 1'b0;
			hex = 1'b0;
			mode = (c == "0") ? M_ZERO : M_NUM;
			return;
		end
		if (alpha(c)) begin
			mark_start();
			tlen = '0;
			kw_hits = '1;
			mode = M_IDENT;
			word_char(c);
			return;
		end
		if (c == "\"") begin
			mark_start();
			tlen = '0;
			mode = M_STRING;
			return;
		end
		case (c)
			"(": ty = T_LPAREN; ")": ty = T_RPAREN; "{": ty = T_LBRACE; "}": ty = T_RBRACE;
			"[": ty = T_LBRACK; "]": ty = T_RBRACK; ";": ty = T_SEMI; ",": ty = T_COMMA;
			".": ty = T_DOT; "+": ty = T_PLUS; "-": ty = T_MINUS; "*": ty = T_STAR;
			"%": ty = T_PERCENT; "^": ty = T_CARET; "~": ty = T_TILDE;
			"=", "!", "&", "|", "<", ">", "/": begin
				mark_start();
				op_char = c;
				mode = M_OP;
				return;
			end
			default: begin
				put_error(ERR_UNEXPECTED, line_no, col_no);
				return;
			end
		endcase
		put_token(ty, line_no, col_no, 32'h0, '0);
	endtask

	task automatic number_digit(logic [7:0] c);
		logic [63:0] d;
		if (hex) begin
			if (digit(c)) d = 64'(c - "0");
			else if (c >= "a" && c <= "f") d = 64'(c - "a" + 8'd10);
			else if (c >= "A" && c <= "F") d = 64'(c - "A" + 8'd10);
			else begin
				flush_number();
				scan_idle(c);
				return;
			end
			if (accum > 64'h0FFF_FFFF_FFFF_FFFF) ovf = 1'b1;
			if (!ovf) accum = {accum[59:0], d[3:0]};
		end else begin
			if (!digit(c)) begin
				flush_number();
				scan_idle(c);
				return;
			end
			d = 64'(c - "0");
			if (accum > (64'h7FFF_FFFF_FFFF_FFFF - d) / 64'd10) ovf = 1'b1;
			if (!ovf) accum = accum * 64'd10 + d;
		end
	endtask

	task automatic lex_char(logic [7:0] c);
		logic [5:0] ty;
		logic [8:0] d;
		case (mode)
			M_ZERO: begin
				if (c == "x" || c == "X") begin
					hex = 1'b1;
					accum = '0;
					mode = M_NUM;
				end else if (!digit(c)) begin
					flush_number();
					scan_idle(c);
				end else begin
					mode = M_NUM;
					number_digit(c);
				end
			end
			M_NUM: number_digit(c);
			M_IDENT: begin
				if (alpha(c) || digit(c)) word_char(c);
				else begin
					flush_word();
					scan_idle(c);
				end
			end
			M_STRING: begin
				if (c == "\"") begin
					put_token(T_STRING, tok_line, tok_col, 32'h0, tlen);
					mode = M_IDLE;
				end else if (c == "\n") begin
					put_error(ERR_UNTERM, tok_line, tok_col);
					dead = 1'b1;
				end else if (c == "\\") mode = M_ESCAPE;
				else put_text(T_STRING, c);
			end
			M_ESCAPE: begin
				case (c)
					"n": d = 9'h0A; "t": d = 9'h09; "r": d = 9'h0D; "0": d = 9'h00;
					"\\": d = 9'h5C; "\"": d = 9'h22; default: d = 9'h100;
				endcase
				if (d[8]) begin
					put_error(ERR_ESCAPE, line_no, col_no);
					dead = 1'b1;
				end else begin
					put_text(T_STRING, d[7:0]);
					mode = M_STRING;
				end
			end
			M_OP: begin
				ty = T_INT;
				if (op_char == "/" && c == "/") begin
					doc = 1'b0;
					mode = M_LINECOM;
					return;
				end
				if (op_char == "/" && c == "*") begin
					mode = M_BLKFIRST;
					return;
				end
				if (op_char != "/" && c == "=" && op_char inside {"=", "!", "<", ">"})
					case (op_char)
						"=": ty = T_EQ; "!": ty = T_NE; "<": ty = T_LE; default: ty = T_GE;
					endcase
				else if (op_char != "/" && c == op_char && op_char inside {"&", "|", "<", ">"})
					case (op_char)
						"&": ty = T_ANDAND; "|": ty = T_OROR; "<": ty = T_SHL; default: ty = T_SHR;
					endcase
				if (ty != T_INT) begin
					put_token(ty, tok_line, tok_col, 32'h0, '0);
					mode = M_IDLE;
				end else begin
					flush_op();
					scan_idle(c);
				end
			end
			M_LINECOM: if (c == "\n") mode = M_IDLE;
			M_BLKFIRST: begin
				in_doc = (c == "*");
				star = (c == "*");
				mode = M_BLOCK;
			end
			M_BLOCK: begin
				if (star && c == "/") begin
					doc = in_doc;
					mode = M_IDLE;
				end else star = (c == "*");
			end
			default: scan_idle(c);
		endcase
	endtask

	task automatic rewind();
		mode = M_IDLE; op_char = '0; line_no = LINE_WIDTH'(1); col_no = COL_WIDTH'(1);
		tok_line = LINE_WIDTH'(1); tok_col = COL_WIDTH'(1);
		accum = '0; ovf = 1'b0; hex = 1'b0; tlen = '0; kw_hits = '0;
		doc = 1'b0; in_doc = 1'b0; star = 1'b0; dead = 1'b0;
	endtask

	task automatic predict_beat(src_t s);
		bit stop, failed;
		stop = s.is_end || s.ch == 8'h00;
		failed = 0;
		step_recs.delete();
		if (stop) begin
			if (!dead) begin
				case (mode)
					M_ZERO, M_NUM: flush_number();
					M_IDENT: flush_word();
					M_OP: flush_op();
					M_STRING: begin
						put_error(ERR_UNTERM, tok_line, tok_col);
						failed = 1;
					end
					M_ESCAPE: begin
						put_error(ERR_ESCAPE, line_no, col_no);
						failed = 1;
					end
					default: ;
				endcase
				if (!failed) put(KIND_TOKEN, T_EOF, line_no, col_no, 32'h0, '0, 1'b0, 8'h00, 2'd0);
			end
			rewind();
		end else if (!dead) begin
			lex_char(s.ch);
			if (s.ch == "\n") begin
				if (line_no != LINE_MAX) line_no++;
				col_no = COL_WIDTH'(1);
			end else if (col_no != COL_MAX) col_no++;
		end
		if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last_of_step = 1'b1;
		foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic compare_record(res_t got);
		res_t want;
		if (expected_recs.size() == 0) begin
			report("unexpected record", 64'(got.token_type), 64'd0);
			return;
		end
		want = expected_recs.pop_front();
		if (got.kind != want.kind) report("kind", 64'(got.kind), 64'(want.kind));
		if (got.token_type != want.token_type)
			report("token_type", 64'(got.token_type), 64'(want.token_type));
		if (got.start_line != want.start_line)
			report("start_line", 64'(got.start_line), 64'(want.start_line));
		if (got.start_column != want.start_column)
			report("start_column", 64'(got.start_column), 64'(want.start_column));
		if (got.lit_value != want.lit_value)
			report("lit_value", 64'(unsigned'(got.lit_value)), 64'(unsigned'(want.lit_value)));
		if (got.text_len != want.text_len)
			report("text_len", 64'(got.text_len), 64'(want.text_len));
		if (got.has_doc != want.has_doc) report("has_doc", 64'(got.has_doc), 64'(want.has_doc));
		if (got.text_byte != want.text_byte)
			report("text_byte", 64'(got.text_byte), 64'(want.text_byte));
		if (got.error_code != want.error_code)
			report("error_code", 64'(got.error_code), 64'(want.error_code));
		if (got.last_of_step != want.last_of_step)
			report("last_of_step", 64'(got.last_of_step), 64'(want.last_of_step));
	endtask

	initial begin
		fail_count = 0;
		pending_count = 0;
		rewind();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) compare_record(tok);
			if (push && !full) predict_beat(src);
			pending_count = expected_recs.size();
		end
	end
endmodule

/* verif/c_like_source_lexer_top_test.sv */
// Stimulus and verdict for the C-like source lexer testbench.
`timescale 1ns / 100ps
module c_like_source_lexer_top_test;
	import clsl_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic pop = 0;
	src_t src = '0;
	logic full, empty;
	res_t tok;
	int   fail_count, pending_count;
	bit   hold_reader = 0;
	bit   feeding_done = 0;
	int   sent = 0;

	// Fragments of well-formed source; random streams mostly splice these together.
	string snippets[$] = '{
		"int", "if", "else", "while", "for", "return", "recursive", "include",
		"struct", "extern", "void", "byte", "version", "in", "inte", "versions",
		"_x9", "Foo", "12345", "0", "007", "0x1F", "0XaB", "0xFFFFFFFFFFFFFFFF1",
		"99999999999999999999", "9223372036854775807", "\"hi\\n\\t\\r\\0\\\\\\\"\"",
		"\"abc\"", "\"\"", "( ) { } [ ] ; , . + - * % ^ ~", "= == ! != & && | ||",
		"< <= << > >= >>", "a/b", "// note\n", "/* plain */", "/** doc */ x",
		"/**/", "/***/", "\n", " ", "\t", "\r", "@", "$", "#"
	};

	always #4 clk = ~clk;

	c_like_source_lexer_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .src(src),
		.empty(empty), .pop(pop), .tok(tok)
	);

	c_like_source_lexer_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .src(src),
		.empty(empty), .pop(pop), .tok(tok),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// Offer one beat, wait out a random gap first, hold until taken.
	task automatic send_beat(logic [7:0] c, logic stop);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		src <= '{ch: c, is_end: stop};
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
	endtask

	// Reader: random stalls per beat, sometimes none at all.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				pop <= 0;
				repeat (stall) @(posedge clk);
			end
			pop <= !hold_reader;
			@(posedge clk);
		end
	end

	// Long reader hold-off early on, so the queue fills and backs up the writer.
	initial begin
		@(posedge arst_n);
		repeat (20) @(posedge clk);
		hold_reader = 1;
		repeat (300) @(posedge clk);
		hold_reader = 0;
	end

	initial begin
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: keywords, extremes, doc marks, errors, ends.
		send_text("/** d */int 0x7 ");
		send_beat(8'h00, 1'b0);
		send_text("\"a\\q");
		send_beat(8'hFF, 1'b1);
		send_text("<= \xff");
		send_beat(8'h00, 1'b1);
		send_text("\"x\n");
		send_beat(8'h41, 1'b1);

		while (sent < 1800) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) send_text(snippets[$urandom_range(0, snippets.size() - 1)]);
			else if (pick < 16) send_text(" ");
			else if (pick < 19)
				send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
			else send_beat(8'($urandom_range(0, 255)), 1'b1);
		end
		send_beat(8'h00, 1'b1);
		push <= 0;
		feeding_done = 1;
	end

	initial begin
		wait (feeding_done);
		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end
endmodule
